[src/sidtoa_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; imported by sidtoa_front, sidtoa_back and the top level.
package sidtoa_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_TRIM,
    BK_EMIT
  } bk_state_e;

endpackage

[src/sidtoa_front.sv]
// Front end: accepts input values, splits sign and magnitude, and holds them
// in a two-entry queue for the back end. Depends on sidtoa_pkg.
module sidtoa_front import sidtoa_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output logic                   q_neg_o,
  output logic [VALUE_WIDTH-1:0] q_mag_o
);

  logic [VALUE_WIDTH-1:0] mag_q [2];
  logic                   neg_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;

  assign in_neg     = value_i[VALUE_WIDTH-1];
  assign in_mag     = in_neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_neg_o    = neg_q[rd_ptr_q];
  assign q_mag_o    = mag_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mag_q[wr_ptr_q] <= in_mag;
      neg_q[wr_ptr_q] <= in_neg;
    end
  end

endmodule

[src/sidtoa_back.sv]
// Back end: shift-add-3 binary to BCD conversion, leading zero trim and
// character emission through an output register. Depends on sidtoa_pkg.
module sidtoa_back import sidtoa_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  logic                   q_neg_i,
  input  logic [VALUE_WIDTH-1:0] q_mag_i,
  output logic [7:0]             char_code_o,
  output logic                   last_char_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i
);

  localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_WIDTH);
  localparam int DW   = $clog2(NDIG + 1);

  bk_state_e              state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic                   neg_q, neg_d;
  logic [CW-1:0]          step_q, step_d;
  logic [DW-1:0]          dig_q, dig_d;
  logic [7:0]             chr_q, chr_d;
  logic                   last_q, last_d;
  logic                   valid_q, valid_d;
  logic [BW-1:0]          adj;
  logic [3:0]             top;
  logic                   out_free;
  logic                   emit_last;

  assign top       = bcd_q[BW-1 -: 4];
  assign out_free  = !valid_q || out_ready_i;
  assign emit_last = !neg_q && (dig_q == DW'(1));

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_CONV;
      BK_CONV: if (step_q == CW'(VALUE_WIDTH - 1)) state_d = BK_TRIM;
      BK_TRIM: if (top != 4'd0 || dig_q == DW'(1)) state_d = BK_EMIT;
      BK_EMIT: if (out_free && emit_last) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    step_d    = step_q;
    dig_d     = dig_q;
    chr_d     = chr_q;
    last_d    = last_q;
    valid_d   = out_ready_i ? 1'b0 : valid_q;
    unique case (state_q)
      BK_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          mag_d  = q_mag_i;
          neg_d  = q_neg_i;
          bcd_d  = '0;
          step_d = '0;
        end
      end
      BK_CONV: begin
        bcd_d  = {adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d  = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        step_d = step_q + CW'(1);
        dig_d  = DW'(NDIG);
      end
      BK_TRIM: begin
        if (top == 4'd0 && dig_q != DW'(1)) begin
          bcd_d = {bcd_q[BW-5:0], 4'd0};
          dig_d = dig_q - DW'(1);
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          valid_d = 1'b1;
          if (neg_q) begin
            chr_d  = CHAR_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            chr_d  = CHAR_ZERO + {4'd0, top};
            last_d = emit_last;
            bcd_d  = {bcd_q[BW-5:0], 4'd0};
            dig_d  = dig_q - DW'(1);
          end
        end
      end
      default: q_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
      neg_q   <= 1'b0;
      step_q  <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      neg_q   <= neg_d;
      step_q  <= step_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    chr_q  <= chr_d;
    last_q <= last_d;
  end

  assign char_code_o = chr_q;
  assign last_char_o = last_q;
  assign out_valid_o = valid_q;

endmodule

[src/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII character stream.
// Depends on sidtoa_pkg, sidtoa_front and sidtoa_back.
//
// Input channel: value_i with in_valid_i/in_ready_o; one transfer per number.
// Output channel: char_code_o and last_char_o with out_valid_o/out_ready_i;
// one transfer per character, most significant first, '-' leading for
// negative values, last_char_o high on the final character.
// A two-entry queue in the front end feeds the converter, so up to two
// numbers are taken while the converter is busy.
// Per number the converter takes the value from the queue, runs the
// shift-add-3 loop over every magnitude bit, trims leading zero digits down
// to at least one digit, then emits one character at a time through the
// one-character output register. A stalled receiver holds the output
// register and stops emission; the queue keeps taking input until it is full.
// Reset empties the queue, idles the converter and clears out_valid_o.
module signed_int_to_decimal_ascii import sidtoa_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic [7:0]             char_code_o,
  output logic                   last_char_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i
);

  logic                   q_valid;
  logic                   q_ready;
  logic                   q_neg;
  logic [VALUE_WIDTH-1:0] q_mag;

  sidtoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_neg_o    (q_neg),
    .q_mag_o    (q_mag)
  );

  sidtoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_neg_i     (q_neg),
    .q_mag_i     (q_mag),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
